// ----- sv/btt_pkg.sv -----
// Shared types and constants of the bucketed transposition table.
`default_nettype none
package btt_pkg;

   localparam int CSR_W         = 11;
   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;
   localparam int HASH_W        = 64;
   localparam int BOARD_W       = 64;
   localparam int EP_W          = 7;
   localparam int DEPTH_W       = 8;
   localparam int PAYLOAD_W     = 64;
   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_CYCLES    = HASH_W / MOD_STEP_BITS;
   localparam int MOD_CNT_W     = $clog2(MOD_CYCLES);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_FETCH  = 1'b1
   } command_type;

   typedef struct packed {
      command_type          command;
      logic [HASH_W-1:0]    hash;
      logic [BOARD_W-1:0]   mover_pawns;
      logic [BOARD_W-1:0]   rival_pawns;
      logic [EP_W-1:0]      en_passant;
      logic [DEPTH_W-1:0]   depth;
      logic [PAYLOAD_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [DEPTH_W-1:0]   depth_out;
      logic [PAYLOAD_W-1:0] payload_out;
   } rsp_type;

   typedef struct packed {
      logic [BOARD_W-1:0]   mover_pawns;
      logic [BOARD_W-1:0]   rival_pawns;
      logic [EP_W-1:0]      en_passant;
      logic [PAYLOAD_W-1:0] payload;
   } slot_type;

   typedef struct packed {
      logic rd;
      logic wr;
   } store_op_type;

endpackage
`default_nettype wire

// ----- sv/btt_mod.sv -----
// Iterative remainder unit that reduces the hash modulo the bucket count.
`default_nettype none
module btt_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [btt_pkg::HASH_W-1:0]  dividend,
   input  wire logic [btt_pkg::CSR_W-1:0]   divisor,
   output logic                             done,
   output logic [btt_pkg::CSR_W-1:0]        remainder
);
   import btt_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [MOD_CNT_W-1:0] count_ff;
   logic [HASH_W-1:0]    dividend_ff;
   logic [CSR_W-1:0]     divisor_ff;
   logic [CSR_W-1:0]     rem_ff;
   logic [CSR_W-1:0]     rem_in;

   always_comb begin
      logic [CSR_W:0]   trial;
      logic [CSR_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < MOD_STEP_BITS; i++) begin
         trial = {r, dividend_ff[HASH_W-1-i]};
         if (trial >= {1'b0, divisor_ff}) begin
            trial = trial - {1'b0, divisor_ff};
         end
         r = trial[CSR_W-1:0];
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == MOD_CNT_W'(MOD_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         divisor_ff  <= divisor;
         rem_ff      <= '0;
      end else if (busy_ff) begin
         dividend_ff <= {dividend_ff[HASH_W-MOD_STEP_BITS-1:0], {MOD_STEP_BITS{1'b0}}};
         rem_ff      <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

// ----- sv/btt_store.sv -----
// Bucket store: depth memory with a clearing pass and key and payload memory.
`default_nettype none
module btt_store #(
   parameter int MAX_BUCKETS = 1024,
   parameter int WAYS        = 4,
   parameter int BW          = 10
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire btt_pkg::store_op_type                  op,
   input  wire logic [BW-1:0]                          addr,
   input  wire logic [WAYS-1:0][btt_pkg::DEPTH_W-1:0]  wr_depth,
   input  wire btt_pkg::slot_type [WAYS-1:0]           wr_slot,
   output logic [WAYS-1:0][btt_pkg::DEPTH_W-1:0]       rd_depth,
   output btt_pkg::slot_type [WAYS-1:0]                rd_slot,
   output logic                                        clearing
);
   import btt_pkg::*;

   logic [WAYS-1:0][DEPTH_W-1:0] depth_mem_ff [MAX_BUCKETS];
   slot_type [WAYS-1:0]          slot_mem_ff  [MAX_BUCKETS];
   logic [WAYS-1:0][DEPTH_W-1:0] rd_depth_ff;
   slot_type [WAYS-1:0]          rd_slot_ff;
   logic                         clearing_ff;
   logic [BW-1:0]                clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clearing_ff) begin
         if (clear_addr_ff == BW'(MAX_BUCKETS - 1)) begin
            clearing_ff <= 1'b0;
         end else begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         depth_mem_ff[clear_addr_ff] <= '0;
      end else if (op.wr) begin
         depth_mem_ff[addr] <= wr_depth;
      end
      if (op.rd) begin
         rd_depth_ff <= depth_mem_ff[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (op.wr) begin
         slot_mem_ff[addr] <= wr_slot;
      end
      if (op.rd) begin
         rd_slot_ff <= slot_mem_ff[addr];
      end
   end

   assign rd_depth = rd_depth_ff;
   assign rd_slot  = rd_slot_ff;
   assign clearing = clearing_ff;

endmodule
`default_nettype wire

// ----- sv/bucketed_transposition_table.sv -----
// Top level of the bucketed transposition table with depth-preferred replacement.
//
//   Channel  Direction  Ports                          Transfer
//   req      in         req_valid req_ready req_data   valid and ready high at an edge
//   rsp      out        rsp_valid rsp_ready rsp_data   valid and ready high at an edge
//   csr      in         csr_wr_en csr_wr_data          write enable high at an edge
//
// An item passes through the transfer, the remainder unit that retires four hash
// bits a cycle, a bucket read and a compare with write-back; the next request is
// taken only after that. A fetch with no buckets in use skips the remainder unit.
// Inserts give no response.
// After reset a clearing pass over all MAX_BUCKETS buckets zeroes the depth memory; no
// request is taken during it. A fetch waits in its compare state while the response
// register is still full.
`default_nettype none
module bucketed_transposition_table #(
   parameter int MAX_BUCKETS = 1024,
   parameter int WAYS        = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire btt_pkg::req_type           req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output btt_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_wr_en,
   input  wire logic [btt_pkg::CSR_W-1:0]  csr_wr_data
);
   import btt_pkg::*;

   localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_EVAL
   } state_type;

   state_type                    state_ff;
   logic [CSR_W-1:0]             buckets_ff;
   logic [CSR_W-1:0]             buckets_eff;
   req_type                      req_ff;
   logic                         disabled_ff;
   logic [BW-1:0]                bucket_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_ff;
   rsp_type                      rsp_in;
   logic                         accept;
   logic                         mod_start;
   logic                         mod_done;
   logic [CSR_W-1:0]             mod_rem;
   store_op_type                 op;
   logic [BW-1:0]                store_addr;
   logic [WAYS-1:0][DEPTH_W-1:0] rd_depth;
   slot_type [WAYS-1:0]          rd_slot;
   logic [WAYS-1:0][DEPTH_W-1:0] wr_depth;
   slot_type [WAYS-1:0]          wr_slot;
   logic                         clearing;
   logic [WW-1:0]                ins_way;
   logic [WW-1:0]                hit_way;
   logic                         hit;
   logic                         rsp_free;
   logic                         rsp_load;
   slot_type                     new_slot;

   assign buckets_eff = ({21'd0, buckets_ff} > 32'(MAX_BUCKETS))
                        ? CSR_W'(MAX_BUCKETS) : buckets_ff;
   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign mod_start   = accept && (buckets_eff != '0);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_load    = (state_ff == ST_EVAL) && (req_ff.command == CMD_FETCH) && rsp_free;

   btt_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_data.hash),
      .divisor   (buckets_eff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      op.rd      = (state_ff == ST_MOD) && mod_done;
      op.wr      = (state_ff == ST_EVAL) && !disabled_ff && (req_ff.command == CMD_INSERT);
      store_addr = op.rd ? BW'(mod_rem) : bucket_ff;
   end

   btt_store #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .WAYS        (WAYS),
      .BW          (BW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .addr     (store_addr),
      .wr_depth (wr_depth),
      .wr_slot  (wr_slot),
      .rd_depth (rd_depth),
      .rd_slot  (rd_slot),
      .clearing (clearing)
   );

   always_comb begin
      ins_way = WW'(WAYS - 1);
      hit_way = '0;
      hit     = 1'b0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (req_ff.depth > rd_depth[w]) begin
            ins_way = WW'(w);
         end
         if ((rd_depth[w] != '0) && (rd_slot[w].mover_pawns == req_ff.mover_pawns) &&
             (rd_slot[w].rival_pawns == req_ff.rival_pawns) &&
             (rd_slot[w].en_passant == req_ff.en_passant)) begin
            hit_way = WW'(w);
            hit     = 1'b1;
         end
      end
      hit = hit && !disabled_ff;

      new_slot.mover_pawns = req_ff.mover_pawns;
      new_slot.rival_pawns = req_ff.rival_pawns;
      new_slot.en_passant  = req_ff.en_passant;
      new_slot.payload     = req_ff.payload;
      wr_depth             = rd_depth;
      wr_slot              = rd_slot;
      wr_depth[ins_way]    = req_ff.depth;
      wr_slot[ins_way]     = new_slot;

      rsp_in.hit         = hit;
      rsp_in.depth_out   = hit ? rd_depth[hit_way] : '0;
      rsp_in.payload_out = hit ? rd_slot[hit_way].payload : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         buckets_ff   <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
         disabled_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            buckets_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (!clearing) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  disabled_ff <= (buckets_eff == '0);
                  if (buckets_eff != '0) begin
                     state_ff <= ST_MOD;
                  end else if (req_data.command == CMD_FETCH) begin
                     state_ff <= ST_EVAL;
                  end
               end
            end
            ST_MOD: begin
               if (mod_done) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               if (req_ff.command == CMD_INSERT) begin
                  state_ff <= ST_IDLE;
               end else if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if ((state_ff == ST_MOD) && mod_done) begin
         bucket_ff <= BW'(mod_rem);
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- dv/bucketed_transposition_table_test.sv -----
// Self-checking testbench of the bucketed transposition table with random handshake gaps.
`timescale 1ns / 100ps
module bucketed_transposition_table_test;
   import btt_pkg::*;

   localparam int MAX_BUCKETS   = 1024;
   localparam int WAYS          = 4;
   localparam int SLOT_COUNT    = MAX_BUCKETS * WAYS;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_COUNT   = 8;
   localparam logic [CSR_W-1:0] PHASE_BUCKETS [PHASE_COUNT] =
      '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd3, 11'd1000, 11'd17, 11'd1};

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   req_type            request_queue [$];
   rsp_type            lookup_answers [$];
   req_type            known_positions [$];
   logic [HASH_W-1:0]  hash_pool [$];
   logic [DEPTH_W-1:0] shadow_depth [SLOT_COUNT];
   slot_type           shadow_slot [SLOT_COUNT];
   logic [CSR_W-1:0]   shadow_buckets;
   logic               req_fire;
   bit                 idling;
   int unsigned        gap_left;
   int unsigned        stall_left;
   int unsigned        mismatch_count;

   bucketed_transposition_table #(
      .MAX_BUCKETS(MAX_BUCKETS),
      .WAYS(WAYS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   function automatic int unsigned pause_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         return $urandom_range(1, 3);
      end else if (roll < 92) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] random_board();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
         return '0;
      end else if (roll == 1) begin
         return '1;
      end
      return random_word();
   endfunction

   function automatic req_type make_req(input command_type command,
                                        input logic [HASH_W-1:0] hash,
                                        input logic [BOARD_W-1:0] mine,
                                        input logic [BOARD_W-1:0] theirs,
                                        input logic [EP_W-1:0] ep,
                                        input logic [DEPTH_W-1:0] depth,
                                        input logic [PAYLOAD_W-1:0] payload);
      req_type r;
      r.command     = command;
      r.hash        = hash;
      r.mover_pawns = mine;
      r.rival_pawns = theirs;
      r.en_passant  = ep;
      r.depth       = depth;
      r.payload     = payload;
      return r;
   endfunction

   function automatic req_type random_position();
      req_type r;
      r.command     = CMD_FETCH;
      r.hash        = ($urandom_range(0, 4) != 0) ?
                      hash_pool[$urandom_range(0, hash_pool.size() - 1)] : random_word();
      r.mover_pawns = random_board();
      r.rival_pawns = random_board();
      r.en_passant  = ($urandom_range(0, 4) != 0) ? 7'($urandom_range(0, 64)) :
                      7'($urandom_range(0, 127));
      r.depth       = 8'($urandom);
      r.payload     = random_word();
      return r;
   endfunction

   // A mix of inserts and fetches of the same positions, with near misses and noise.
   function automatic req_type random_request();
      req_type r;
      int unsigned roll;
      int unsigned bit_pos;
      roll = $urandom_range(0, 99);
      if (known_positions.size() == 0 || roll < 45) begin
         if (known_positions.size() != 0 && $urandom_range(0, 2) == 0) begin
            r = known_positions[$urandom_range(0, known_positions.size() - 1)];
         end else begin
            r = random_position();
         end
         r.command = CMD_INSERT;
         r.depth   = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
         r.payload = random_word();
         known_positions.push_back(r);
         if (known_positions.size() > 32) begin
            void'(known_positions.pop_front());
         end
      end else begin
         r = (roll < 93) ? known_positions[$urandom_range(0, known_positions.size() - 1)] :
             random_position();
         r.command = CMD_FETCH;
         if (roll >= 85 && roll < 93) begin
            bit_pos = $urandom_range(0, 2 * BOARD_W + EP_W - 1);
            if (bit_pos < BOARD_W) begin
               r.mover_pawns[bit_pos] = ~r.mover_pawns[bit_pos];
            end else if (bit_pos < 2 * BOARD_W) begin
               r.rival_pawns[bit_pos - BOARD_W] = ~r.rival_pawns[bit_pos - BOARD_W];
            end else begin
               r.en_passant[bit_pos - 2 * BOARD_W] = ~r.en_passant[bit_pos - 2 * BOARD_W];
            end
         end
         r.depth   = 8'($urandom);
         r.payload = random_word();
      end
      return r;
   endfunction

   // Applies one accepted transfer to the shadow store and queues the answer of a fetch.
   task automatic update_shadow_store(input req_type r);
      int unsigned n;
      int unsigned base;
      int unsigned slot;
      rsp_type answer;
      n      = (shadow_buckets > MAX_BUCKETS) ? MAX_BUCKETS : shadow_buckets;
      base   = 0;
      answer = '0;
      if (n != 0) begin
         base = 32'(r.hash % 64'(n)) * WAYS;
      end
      if (r.command == CMD_INSERT) begin
         if (n == 0) begin
            return;
         end
         for (int w = 0; w < WAYS; w++) begin
            slot = base + w;
            if (r.depth > shadow_depth[slot] || w == WAYS - 1) begin
               shadow_depth[slot]             = r.depth;
               shadow_slot[slot].mover_pawns = r.mover_pawns;
               shadow_slot[slot].rival_pawns = r.rival_pawns;
               shadow_slot[slot].en_passant  = r.en_passant;
               shadow_slot[slot].payload     = r.payload;
               break;
            end
         end
      end else begin
         if (n != 0) begin
            for (int w = 0; w < WAYS; w++) begin
               slot = base + w;
               if (shadow_depth[slot] != 0 &&
                   shadow_slot[slot].mover_pawns == r.mover_pawns &&
                   shadow_slot[slot].rival_pawns == r.rival_pawns &&
                   shadow_slot[slot].en_passant == r.en_passant) begin
                  answer.hit         = 1'b1;
                  answer.depth_out   = shadow_depth[slot];
                  answer.payload_out = shadow_slot[slot].payload;
                  break;
               end
            end
         end
         lookup_answers.push_back(answer);
      end
   endtask

   task automatic check_lookup(input rsp_type got);
      rsp_type want;
      if (lookup_answers.size() == 0) begin
         report_mismatch($sformatf("response with none expected: %p", got));
         return;
      end
      want = lookup_answers.pop_front();
      if (got.hit !== want.hit) begin
         report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
      end
      if (got.depth_out !== want.depth_out) begin
         report_mismatch($sformatf("depth_out %0d, expected %0d",
                                   got.depth_out, want.depth_out));
      end
      if (got.payload_out !== want.payload_out) begin
         report_mismatch($sformatf("payload_out %h, expected %h",
                                   got.payload_out, want.payload_out));
      end
   endtask

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            update_shadow_store(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_lookup(rsp_data);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            req_data  <= request_queue.pop_front();
            req_valid <= 1'b1;
            gap_left = (idling && $urandom_range(0, 2) == 0) ? pause_length() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = pause_length();
         end
      end
   end

   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (request_queue.size() != 0 || req_valid || lookup_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bucket_count(input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      shadow_buckets = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) request_queue.push_back(random_request());
   endtask

   initial begin
      req_type landmark;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      idling         = 1'b1;
      gap_left       = 0;
      stall_left     = 0;
      mismatch_count = 0;
      shadow_buckets = CSR_RESET;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_depth[i] = '0;
         shadow_slot[i]  = '0;
      end
      repeat (24) hash_pool.push_back(random_word());
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table, an invisible zero-depth entry, extreme fields and raw en-passant codes.
      request_queue.push_back(make_req(CMD_FETCH, '0, '0, '0, 7'd0, 8'd0, '0));
      request_queue.push_back(make_req(CMD_INSERT, '0, '0, '0, 7'd0, 8'd0, 64'd5));
      request_queue.push_back(make_req(CMD_FETCH, '0, '0, '0, 7'd0, 8'd0, '0));
      request_queue.push_back(make_req(CMD_INSERT, '1, '1, '0, 7'd64, 8'd255, '1));
      request_queue.push_back(make_req(CMD_FETCH, '1, '1, '0, 7'd64, 8'd0, '0));
      request_queue.push_back(make_req(CMD_INSERT, 64'd5, 64'h00ff_0000_0000_ff00,
                                       64'h0000_ff00_00ff_0000, 7'd127, 8'd1,
                                       64'h0123_4567_89ab_cdef));
      request_queue.push_back(make_req(CMD_FETCH, 64'd5, 64'h00ff_0000_0000_ff00,
                                       64'h0000_ff00_00ff_0000, 7'd127, 8'd0, '0));
      request_queue.push_back(make_req(CMD_FETCH, 64'd5, 64'h00ff_0000_0000_ff00,
                                       64'h0000_ff00_00ff_0000, 7'd63, 8'd0, '0));
      // Overfill one bucket so that replacement by depth and the last-slot fallback occur.
      for (int k = 0; k < 5; k++) begin
         request_queue.push_back(make_req(CMD_INSERT, 64'd7 + 64'd1024 * k, 64'(k + 1),
                                          64'(k + 100), 7'(k), 8'(k == 0 ? 10 : k == 1 ? 20 :
                                          k == 2 ? 5 : k == 3 ? 30 : 7), 64'(k + 1000)));
      end
      request_queue.push_back(make_req(CMD_INSERT, 64'd7, 64'd9, 64'd9, 7'd9, 8'd0, 64'd9));
      for (int k = 0; k < 5; k++) begin
         request_queue.push_back(make_req(CMD_FETCH, 64'd7 + 64'd1024 * k, 64'(k + 1),
                                          64'(k + 100), 7'(k), 8'd0, '0));
      end
      landmark = make_req(CMD_FETCH, 64'd7 + 64'd1024 * 5, 64'd4, 64'd103, 7'd3, 8'd0, '0);
      request_queue.push_back(landmark);
      queue_random(50);
      wait_until_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         idling = (phase % 3) != 2;
         write_bucket_count(PHASE_BUCKETS[phase]);
         request_queue.push_back(landmark);
         request_queue.push_back(make_req(CMD_INSERT, '1, '1, '1, 7'h7f, 8'hff, '1));
         request_queue.push_back(make_req(CMD_FETCH, '1, '1, '1, 7'h7f, 8'h00, '0));
         queue_random(40);
         wait_until_drained();
      end

      if (mismatch_count == 0) begin
         $display("PASS bucketed_transposition_table");
      end else begin
         $display("FAIL bucketed_transposition_table");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL bucketed_transposition_table");
      $finish;
   end

endmodule
